/* rtl/motion_baseline_detector_unit_assert.svh */
// ---------------------------------------------------------------------------
// motion baseline detector assertion macros
// property shorthands sampled on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef MOTION_BASELINE_DETECTOR_UNIT_ASSERT_SVH
`define MOTION_BASELINE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbd assertion failed");

// next-cycle implication
`define MBD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbd assertion failed");

`endif

/* rtl/mbd_pkg.sv */
// ---------------------------------------------------------------------------
// mbd_pkg
// widths, register codes, sequencer states and lane control for the
// motion baseline detector
// ---------------------------------------------------------------------------
package mbd_pkg;

	localparam int SAMPLE_BITS  = 14;
	localparam int FRAC_BITS    = 16;
	localparam int BASE_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int WEIGHT_BITS  = 16;
	localparam int CNT_BITS     = 8;
	localparam int PCT_BITS     = 7;
	localparam int NUM_AXES     = 3;
	localparam int MEAN_BITS    = BASE_BITS + CNT_BITS;
	localparam int PROD_BITS    = BASE_BITS + WEIGHT_BITS;
	localparam int DEV_BITS     = BASE_BITS + PCT_BITS;
	localparam int DIV_CNT_BITS = $clog2(BASE_BITS);
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_BITS     = 16;

	localparam logic [PROD_BITS:0]   WEIGHT_ROUND = (PROD_BITS + 1)'((1 << WEIGHT_BITS) - 1);
	localparam logic [PCT_BITS-1:0]  PCT_HUNDRED  = PCT_BITS'(100);

	localparam logic [CNT_BITS-1:0]    STAB_RESET   = CNT_BITS'(50);
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(6554);
	localparam logic [PCT_BITS-1:0]    PCT_RESET    = PCT_BITS'(5);

	localparam logic [CFG_IDX_BITS-1:0] CFG_STAB   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_PCT    = CFG_IDX_BITS'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_UPD,
		ST_DEVM,
		ST_DEVC
	} state_t;

	typedef struct packed {
		logic                load;
		logic                mul;
		logic                mean;
		logic                div;
		logic                upd;
		logic                devm;
		logic [CNT_BITS-1:0] n;
	} lane_ctrl_t;

endpackage

/* rtl/mbd_sample_if.sv */
// ---------------------------------------------------------------------------
// mbd_sample_if
// valid/ready channel carrying one three-axis sample per beat
// ---------------------------------------------------------------------------
interface mbd_sample_if;

	logic                         valid;
	logic                         ready;
	logic [mbd_pkg::SAMPLE_BITS-1:0] sample_x;
	logic [mbd_pkg::SAMPLE_BITS-1:0] sample_y;
	logic [mbd_pkg::SAMPLE_BITS-1:0] sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);

endinterface

/* rtl/mbd_result_if.sv */
// ---------------------------------------------------------------------------
// mbd_result_if
// valid/ready channel carrying one movement result per beat
// ---------------------------------------------------------------------------
interface mbd_result_if;

	logic valid;
	logic ready;
	logic movement;
	logic calibrated;

	modport source (output valid, output movement, output calibrated, input ready);
	modport sink (input valid, input movement, input calibrated, output ready);

endinterface

/* rtl/mbd_lane.sv */
// ---------------------------------------------------------------------------
// mbd_lane
// one axis: baseline register, running-mean restoring divider, exponential
// average update and percent deviation test
// ---------------------------------------------------------------------------
module mbd_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbd_pkg::lane_ctrl_t                 ctrl,
	input  logic [mbd_pkg::SAMPLE_BITS-1:0]     sample,
	input  logic [mbd_pkg::WEIGHT_BITS-1:0]     weight,
	input  logic [mbd_pkg::PCT_BITS-1:0]        pct,
	output logic                                dev
);

	logic [mbd_pkg::BASE_BITS-1:0]   b_q;
	logic [mbd_pkg::BASE_BITS-1:0]   s_q;
	logic                            ge_q;
	logic [mbd_pkg::PROD_BITS-1:0]   prod_q;
	logic [mbd_pkg::CNT_BITS-1:0]    rem_q;
	logic [mbd_pkg::BASE_BITS-1:0]   quo_q;
	logic [mbd_pkg::DEV_BITS-1:0]    dm_q;
	logic [mbd_pkg::DEV_BITS-1:0]    tb_q;

	logic                            ge;
	logic [mbd_pkg::BASE_BITS-1:0]   absdiff;
	logic [mbd_pkg::MEAN_BITS-1:0]   mean_num;
	logic [mbd_pkg::CNT_BITS-1:0]    divisor;
	logic [mbd_pkg::CNT_BITS:0]      trial;
	logic                            take;
	logic [mbd_pkg::PROD_BITS:0]     prod_r;
	logic [mbd_pkg::BASE_BITS-1:0]   inc;
	logic [mbd_pkg::BASE_BITS-1:0]   dec;
	logic [mbd_pkg::BASE_BITS-1:0]   ema_b;

	assign ge      = s_q >= b_q;
	assign absdiff = ge ? (s_q - b_q) : (b_q - s_q);

	// n < 255 whenever the mean path runs
	assign divisor  = ctrl.n + mbd_pkg::CNT_BITS'(1);
	assign mean_num = mbd_pkg::MEAN_BITS'(b_q) * mbd_pkg::MEAN_BITS'(ctrl.n)
		+ mbd_pkg::MEAN_BITS'(s_q);

	assign trial = {rem_q, quo_q[mbd_pkg::BASE_BITS-1]};
	assign take  = trial >= {1'b0, divisor};

	assign prod_r = {1'b0, prod_q} + mbd_pkg::WEIGHT_ROUND;
	assign inc    = prod_q[mbd_pkg::PROD_BITS-1:mbd_pkg::WEIGHT_BITS];
	assign dec    = prod_r[mbd_pkg::PROD_BITS-1:mbd_pkg::WEIGHT_BITS];
	assign ema_b  = ge_q ? (b_q + inc) : (b_q - dec);

	assign dev = dm_q > tb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (ctrl.upd) begin
			b_q <= ctrl.mean ? quo_q : ema_b;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			s_q <= {sample, {mbd_pkg::FRAC_BITS{1'b0}}};
		end
		if (ctrl.mul) begin
			ge_q <= ge;
			if (ctrl.mean) begin
				{rem_q, quo_q} <= mean_num;
			end else begin
				prod_q <= mbd_pkg::PROD_BITS'(absdiff) * mbd_pkg::PROD_BITS'(weight);
			end
		end
		if (ctrl.div) begin
			rem_q <= take ? mbd_pkg::CNT_BITS'(trial - {1'b0, divisor})
				: trial[mbd_pkg::CNT_BITS-1:0];
			quo_q <= {quo_q[mbd_pkg::BASE_BITS-2:0], take};
		end
		if (ctrl.devm) begin
			dm_q <= mbd_pkg::DEV_BITS'(absdiff) * mbd_pkg::DEV_BITS'(mbd_pkg::PCT_HUNDRED);
			tb_q <= mbd_pkg::DEV_BITS'(pct) * mbd_pkg::DEV_BITS'(b_q);
		end
	end

endmodule

/* rtl/motion_baseline_detector_unit.sv */
// ---------------------------------------------------------------------------
// motion_baseline_detector_unit
// three axis lanes under one sequencer; the merge stage ors the lane
// deviation flags and registers the result beat
// ---------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  samples   in   sample_x, sample_y, sample_z     valid/ready
//  results   out  movement, calibrated             valid/ready
//  cfg       in   cfg_index, cfg_data              cfg_we, no wait
//
//  averaging phase: each beat steps through the mul, div, upd, devm and devc
//  states, div running the restoring divider of each lane; exponential phase skips div
//  result is registered in devc; a new sample beat is taken only in idle
//  reset clears baselines, sample count and calibration flag at once
//  a stalled result holds the sequencer in the compare stage
// ---------------------------------------------------------------------------
`include "motion_baseline_detector_unit_assert.svh"

module motion_baseline_detector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	mbd_sample_if.sink                           samples,
	mbd_result_if.source                         results,
	input  logic                                 cfg_we,
	input  logic [mbd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mbd_pkg::CFG_BITS-1:0]         cfg_data
);

	mbd_pkg::state_t                   state_q, state_d;
	logic [mbd_pkg::CNT_BITS-1:0]      stab_q;
	logic [mbd_pkg::WEIGHT_BITS-1:0]   weight_q;
	logic [mbd_pkg::PCT_BITS-1:0]      pct_q;
	logic [mbd_pkg::CNT_BITS-1:0]      ss_q;
	logic                              done_q;
	logic                              mean_q;
	logic [mbd_pkg::DIV_CNT_BITS-1:0]  cnt_q;
	logic                              out_valid_q;
	logic                              movement_q;
	logic                              calibrated_q;

	mbd_pkg::lane_ctrl_t               ctrl;
	logic                              accept;
	logic                              out_load;
	logic                              cnt_last;
	logic [mbd_pkg::CNT_BITS-1:0]      ss_next;
	logic [mbd_pkg::NUM_AXES-1:0]      dev;
	logic [mbd_pkg::SAMPLE_BITS-1:0]   smp [mbd_pkg::NUM_AXES];

	assign smp[0] = samples.sample_x;
	assign smp[1] = samples.sample_y;
	assign smp[2] = samples.sample_z;

	assign samples.ready = state_q == mbd_pkg::ST_IDLE;
	assign accept        = samples.valid && samples.ready;
	assign cnt_last      = cnt_q == mbd_pkg::DIV_CNT_BITS'(mbd_pkg::BASE_BITS - 1);
	assign ss_next       = mean_q ? ss_q + mbd_pkg::CNT_BITS'(1) : ss_q;

	assign results.valid      = out_valid_q;
	assign results.movement   = movement_q;
	assign results.calibrated = calibrated_q;

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		ctrl.mean = mean_q;
		ctrl.n    = ss_q;
		out_load  = 1'b0;
		case (state_q)
			mbd_pkg::ST_IDLE: begin
				ctrl.load = accept;
				if (accept) begin
					state_d = mbd_pkg::ST_MUL;
				end
			end
			mbd_pkg::ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = mean_q ? mbd_pkg::ST_DIV : mbd_pkg::ST_UPD;
			end
			mbd_pkg::ST_DIV: begin
				ctrl.div = 1'b1;
				if (cnt_last) begin
					state_d = mbd_pkg::ST_UPD;
				end
			end
			mbd_pkg::ST_UPD: begin
				ctrl.upd = 1'b1;
				state_d  = mbd_pkg::ST_DEVM;
			end
			mbd_pkg::ST_DEVM: begin
				ctrl.devm = 1'b1;
				state_d   = mbd_pkg::ST_DEVC;
			end
			mbd_pkg::ST_DEVC: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = mbd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mbd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stab_q   <= mbd_pkg::STAB_RESET;
			weight_q <= mbd_pkg::WEIGHT_RESET;
			pct_q    <= mbd_pkg::PCT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mbd_pkg::CFG_STAB:   stab_q   <= cfg_data[mbd_pkg::CNT_BITS-1:0];
				mbd_pkg::CFG_WEIGHT: weight_q <= cfg_data[mbd_pkg::WEIGHT_BITS-1:0];
				mbd_pkg::CFG_PCT:    pct_q    <= cfg_data[mbd_pkg::PCT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q        <= '0;
			done_q      <= 1'b0;
			mean_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mean_q <= ss_q < stab_q;
			end
			if (ctrl.mul) begin
				cnt_q <= '0;
			end else if (ctrl.div) begin
				cnt_q <= cnt_q + mbd_pkg::DIV_CNT_BITS'(1);
			end
			if (ctrl.upd) begin
				ss_q   <= ss_next;
				done_q <= done_q || (ss_next >= stab_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			movement_q   <= done_q && (|dev);
			calibrated_q <= done_q;
		end
	end

	for (genvar a = 0; a < mbd_pkg::NUM_AXES; a++) begin : g_lane
		mbd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (smp[a]),
			.weight (weight_q),
			.pct    (pct_q),
			.dev    (dev[a])
		);
	end

	`MBD_ASSERT_IMP(a_busy_not_ready, state_q != mbd_pkg::ST_IDLE, !samples.ready)
	`MBD_ASSERT_IMP(a_div_only_mean, state_q == mbd_pkg::ST_DIV, mean_q)
	`MBD_ASSERT_NXT(a_done_sticky, done_q, done_q)
	`MBD_ASSERT_IMP(a_move_needs_cal, results.valid && results.movement, results.calibrated)

endmodule
